// File: design/wgm_pkg.sv
// wgm_pkg: shared types and constants of the wildcard glob matcher
// used by wgm_cell and wildcard_glob_matcher; depends on nothing
package wgm_pkg;

   localparam int PatternMax = 32;
   localparam int CountWidth = $clog2(PatternMax + 1);

   localparam logic [7:0] CharStar = 8'h2A;
   localparam logic [7:0] CharAny  = 8'h3F;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_VALUE  = 2'd2,
      OP_END    = 2'd3
   } op_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic       update;
      logic       consume;
      logic       write;
      logic [7:0] symbol;
   } cell_ctl_type;

   // handed from one cell to the next position
   typedef struct packed {
      logic shift;
      logic carry;
   } cell_link_type;

endpackage

// File: design/wgm_cell.sv
// wgm_cell: one pattern position, holding its byte and its active bit
// depends on wgm_pkg
module wgm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  home,
   input  logic                  sel,
   input  logic                  valid,
   input  wgm_pkg::cell_ctl_type ctl,
   input  wgm_pkg::cell_link_type link_in,
   output wgm_pkg::cell_link_type link_out,
   output logic                  active
);

   logic [7:0] char_ff;
   logic       active_ff;
   logic       active_in;
   logic [7:0] char_eff;
   logic       valid_eff;
   logic       is_star;
   logic       char_hit;
   logic       keep;

   // a byte being appended takes part in the same cycle's restart
   assign char_eff  = (ctl.write && sel) ? ctl.symbol : char_ff;
   assign valid_eff = valid || (ctl.write && sel);
   assign is_star   = (char_eff == wgm_pkg::CharStar);
   assign char_hit  = (char_eff == wgm_pkg::CharAny) || (char_eff == ctl.symbol);

   // a star stays active on any byte
   assign keep      = ctl.consume && active_ff && valid_eff && is_star;
   assign active_in = link_in.shift || link_in.carry || keep;

   // star closure ripples forward through runs of stars
   assign link_out.carry = active_in && valid_eff && is_star;
   assign link_out.shift = ctl.consume && active_ff && valid_eff && !is_star && char_hit;

   assign active = active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= home;
      end else if (ctl.update) begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.update && ctl.write && sel) begin
         char_ff <= ctl.symbol;
      end
   end

endmodule

// File: design/wildcard_glob_matcher.sv
// wildcard_glob_matcher: top level, a row of wgm_cell positions and the result register
// depends on wgm_pkg and wgm_cell
//
// Glob matcher for '*' and '?', taking clear, append, value-byte and end requests;
// the set of live pattern positions is held one bit per cell, and a value
// byte moves every live bit one cell on (or keeps it on a star) in that cycle, with the
// star closure rippling through runs of stars along the row. The pattern holds up to
// 32 bytes; a further append sets the overflow flag until the next clear. Only an end
// request gives a result, through an output register: a new request is taken while that
// register is empty or being emptied, so one request per cycle is sustained as long as
// results are taken when offered.
module wildcard_glob_matcher (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_symbol,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_matched,
   output logic       rsp_pattern_overflow
);

   localparam int Max = wgm_pkg::PatternMax;
   localparam int Cw  = wgm_pkg::CountWidth;

   logic [Cw-1:0]          count_ff;
   logic [Cw-1:0]          count_in;
   logic                   overflow_ff;
   logic                   overflow_in;
   logic                   last_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_matched_ff;
   logic                   rsp_overflow_ff;
   logic                   fire;
   logic                   is_clear;
   logic                   is_append;
   logic                   is_value;
   logic                   is_end;
   logic                   hit;
   wgm_pkg::op_type        op;
   wgm_pkg::cell_ctl_type  ctl;
   wgm_pkg::cell_link_type link [Max:0];
   logic [Max:0]           act_vec;

   assign op        = wgm_pkg::op_type'(req_operation);
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;

   always_comb begin
      is_clear  = 1'b0;
      is_append = 1'b0;
      is_value  = 1'b0;
      is_end    = 1'b0;
      unique case (op)
         wgm_pkg::OP_CLEAR:  is_clear  = 1'b1;
         wgm_pkg::OP_APPEND: is_append = 1'b1;
         wgm_pkg::OP_VALUE:  is_value  = 1'b1;
         wgm_pkg::OP_END:    is_end    = 1'b1;
         default:            is_end    = 1'b0;
      endcase
   end

   assign ctl.update  = fire;
   assign ctl.consume = is_value;
   assign ctl.write   = is_append && (count_ff != Cw'(Max));
   assign ctl.symbol  = req_symbol;

   // every request but a value byte restarts the value at position zero
   assign link[0].shift = !is_value;
   assign link[0].carry = 1'b0;

   for (genvar i = 0; i < Max; i++) begin : g_cell
      localparam logic [Cw-1:0] Idx = Cw'(i);
      wgm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .home     ((i == 0) ? 1'b1 : 1'b0),
         .sel      (count_ff == Idx),
         .valid    ((count_ff > Idx) && !is_clear),
         .ctl      (ctl),
         .link_in  (link[i]),
         .link_out (link[i+1]),
         .active   (act_vec[i])
      );
   end

   assign act_vec[Max] = last_ff;
   assign hit          = act_vec[count_ff];

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (is_clear) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (is_append) begin
         if (count_ff == Cw'(Max)) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + Cw'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         last_ff     <= 1'b0;
      end else if (fire) begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         last_ff     <= link[Max].shift || link[Max].carry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && is_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && is_end) begin
         rsp_matched_ff  <= hit && !overflow_ff;
         rsp_overflow_ff <= overflow_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = rsp_matched_ff;
   assign rsp_pattern_overflow = rsp_overflow_ff;

   // an overflowed pattern never reports a match
   a_no_match_on_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_matched_ff && rsp_overflow_ff))
      else $error("match reported with overflowed pattern");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Cw'(Max))
      else $error("pattern count beyond capacity");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (fire && is_clear) |=> (count_ff == '0) && !overflow_ff && act_vec[0])
      else $error("clear did not empty the pattern");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff)
      else $error("request side stalled with no result pending");

endmodule
